// ===== design/fma_pkg.sv =====
// ----------------------------------------------------------------------------
// fma_pkg
// Shared types and constants of the fill markout attribution block.
// ----------------------------------------------------------------------------
package fma_pkg;

  localparam int NUM_HORIZONS_DEF = 4;
  localparam int FIFO_DEPTH_DEF   = 64;

  localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;
  localparam logic [47:0] VOL_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  localparam logic [2:0] REG_OWNER = 3'd0;
  localparam logic [2:0] REG_HCNT  = 3'd1;
  localparam logic [2:0] REG_HZ0   = 3'd2;
  localparam logic [2:0] REG_HZ1   = 3'd3;
  localparam logic [2:0] REG_HZ2   = 3'd4;
  localparam logic [2:0] REG_HZ3   = 3'd5;

  localparam logic REQ_TRADE  = 1'b0;
  localparam logic REQ_SETTLE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_READ,
    ST_CHECK,
    ST_MUL,
    ST_PROD,
    ST_ACC,
    ST_EMIT,
    ST_OUT
  } state_t;

  // input tdata packing, lowest bits first
  localparam int IN_W = 176;

  // output tdata: spread, adverse, edge, drift, volume, count, unsettled
  localparam int OUT_W = 288;

  // saturate a signed 80-bit value to 48 bits
  function automatic logic signed [47:0] sat48(input logic signed [79:0] v);
    logic signed [79:0] hi;
    logic signed [79:0] lo;
    begin
      hi = 80'(ACC_MAX);
      lo = 80'(ACC_MIN);
      if (v > hi) sat48 = ACC_MAX;
      else if (v < lo) sat48 = ACC_MIN;
      else sat48 = v[47:0];
    end
  endfunction

endpackage

// ===== design/fill_markout_attribution.sv =====
// ----------------------------------------------------------------------------
// fill_markout_attribution
// Queues maker fills and attributes their markout over up to four horizons.
// ----------------------------------------------------------------------------
// Sequence: a trade item goes through prep, emit and out; a settle item goes
// through prep, then per active horizon retires each due fill (read, check, then
// multiply, product and add for each of four terms) before emit and out.
// Results leave one a cycle while out_tready is high.
// Throughput: one item at a time; in_tready is high only when idle.
// Reset: sync active-low rst_n clears pointers, sums and mid and resets config.
module fill_markout_attribution #(
  parameter int NUM_HORIZONS = fma_pkg::NUM_HORIZONS_DEF,
  parameter int FIFO_DEPTH   = fma_pkg::FIFO_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // tdata: event_time[47:0], fair_value[87:48], trade_price[111:88],
  // trade_quantity[135:112], aggressor_is_buy[136], rest_owner[144:137],
  // book_mid_twice[169:145], book_two_sided[170], zero fill to 176
  input  logic [fma_pkg::IN_W-1:0]   in_tdata,
  // tuser: req_type
  input  logic                       in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // tdata: spread_gain[47:0], adverse_move[95:48], fair_edge[143:96],
  // fair_drift[191:144], traded_volume[239:192], fill_count[271:240],
  // unsettled_total[280:272], zero fill to 288
  output logic [fma_pkg::OUT_W-1:0]  out_tdata,
  // tuser: horizon_index[1:0], fill_accepted[2], fill_dropped[3]
  output logic [3:0]                 out_tuser,
  // last_result
  output logic                       out_tlast,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [31:0]                cfg_data
);
  import fma_pkg::*;

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int PW = AW + 1;
  localparam int HW = (NUM_HORIZONS > 1) ? $clog2(NUM_HORIZONS) : 1;
  localparam int CW = $clog2(NUM_HORIZONS + 1);

  // configuration
  logic [7:0]  owner_r;
  logic [2:0]  hcnt_r;
  logic [31:0] hz_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_r <= 8'd1;
      hcnt_r  <= 3'd1;
      for (int i = 0; i < 4; i++) hz_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWNER: owner_r <= cfg_data[7:0];
        REG_HCNT:  hcnt_r  <= cfg_data[2:0];
        REG_HZ0:   hz_r[0] <= cfg_data;
        REG_HZ1:   hz_r[1] <= cfg_data;
        REG_HZ2:   hz_r[2] <= cfg_data;
        REG_HZ3:   hz_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the horizon count to 1..NUM_HORIZONS
  logic [CW-1:0] nact;
  always_comb begin
    if (hcnt_r == 3'd0) nact = CW'(1);
    else if (32'(hcnt_r) > 32'(NUM_HORIZONS)) nact = CW'(NUM_HORIZONS);
    else nact = CW'(hcnt_r);
  end

  // fill memory: time, price, mid, fair, size packed in one word
  localparam int MW = 48 + 24 + 25 + 40 + 25;
  logic [MW-1:0] mem [FIFO_DEPTH];
  logic [MW-1:0] rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [MW-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[mem_raddr];
  end

  // state
  state_t state_r, state_nxt;
  logic [PW-1:0] wp_r;
  logic [PW-1:0] rp_r [NUM_HORIZONS];
  logic [24:0]   mid_r;
  logic          seen_r;
  logic signed [47:0] sp_r [NUM_HORIZONS];
  logic signed [47:0] ad_r [NUM_HORIZONS];
  logic signed [47:0] ed_r [NUM_HORIZONS];
  logic signed [47:0] dr_r [NUM_HORIZONS];
  logic [47:0]   vo_r [NUM_HORIZONS];
  logic [31:0]   fc_r [NUM_HORIZONS];

  // captured item
  logic          typ_r;
  logic [47:0]   now_r;
  logic [39:0]   fair_r;
  logic [23:0]   px_r, qty_r;
  logic          buy_r;
  logic [7:0]    own_r;
  logic [24:0]   bmid_r;
  logic          two_r;

  logic [HW-1:0] h_r;
  logic [1:0]    term_r;
  logic signed [41:0] opa_r;
  logic signed [24:0] opb_r;
  logic signed [66:0] prod_r;
  logic          acc_r, drop_r;
  logic [8:0]    unst_r;

  // fields of the fill read
  logic [47:0] f_time;
  logic [23:0] f_px;
  logic [24:0] f_mid;
  logic [39:0] f_fair;
  logic signed [24:0] f_size;
  assign {f_size, f_fair, f_mid, f_px, f_time} = rd_q;

  function automatic logic [PW-1:0] occ(input logic [PW-1:0] w, input logic [PW-1:0] r);
    occ = w - r;
  endfunction

  logic [PW-1:0] rp_cur;
  assign rp_cur = rp_r[h_r];
  logic [31:0] hz_cur;
  assign hz_cur = hz_r[2'(h_r)];
  logic last_h;
  assign last_h = (CW'(h_r) + CW'(1)) == nact;

  // fill is due once its time plus the horizon reaches now; no wrap at 48 bits
  logic due;
  assign due = ({1'b0, f_time} + {17'd0, hz_cur}) <= {1'b0, now_r};

  // next state: a settle retires every horizon in turn, then reports all of them
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_PREP;
      ST_PREP:  state_nxt = (typ_r == REQ_TRADE) ? ST_EMIT : ST_READ;
      ST_READ: begin
        if (occ(wp_r, rp_cur) != '0) state_nxt = ST_CHECK;
        else state_nxt = last_h ? ST_EMIT : ST_READ;
      end
      ST_CHECK: state_nxt = due ? ST_MUL : (last_h ? ST_EMIT : ST_READ);
      ST_MUL:   state_nxt = ST_PROD;
      ST_PROD:  state_nxt = ST_ACC;
      ST_ACC:   state_nxt = (term_r == 2'd3) ? ST_READ : ST_MUL;
      ST_EMIT:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_tready) begin
          if (typ_r == REQ_TRADE || last_h) state_nxt = ST_IDLE;
          else state_nxt = ST_OUT;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  logic take;

  // outputs
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_OUT);
    mem_raddr  = rp_cur[AW-1:0];
    mem_waddr  = wp_r[AW-1:0];
    mem_wdata  = {(buy_r ? -$signed({1'b0, qty_r}) : $signed({1'b0, qty_r})),
                  fair_r, mid_r, px_r, now_r};
    mem_we     = take;
  end

  logic [PW-1:0] occ_all [NUM_HORIZONS];
  logic full;
  always_comb begin
    full = 1'b0;
    for (int i = 0; i < NUM_HORIZONS; i++) begin
      occ_all[i] = occ(wp_r, rp_r[i]);
      if (CW'(i) < nact && occ_all[i] >= PW'(FIFO_DEPTH)) full = 1'b1;
    end
  end

  logic signed [47:0] add_in;
  logic signed [47:0] prod_sat;
  assign prod_sat = sat48(80'(prod_r));
  always_comb begin
    case (term_r)
      2'd0: add_in = sp_r[h_r];
      2'd1: add_in = ad_r[h_r];
      2'd2: add_in = ed_r[h_r];
      default: add_in = dr_r[h_r];
    endcase
  end
  logic signed [47:0] add_out;
  assign add_out = sat48(80'(add_in) + 80'(prod_sat));

  logic [47:0] mag;
  assign mag = 48'(f_size[24] ? -f_size : f_size);

  assign take = (state_r == ST_PREP) && (typ_r == REQ_TRADE) && (own_r == owner_r)
                && seen_r && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wp_r    <= '0;
      mid_r   <= '0;
      seen_r  <= 1'b0;
      for (int i = 0; i < NUM_HORIZONS; i++) begin
        rp_r[i] <= '0; sp_r[i] <= '0; ad_r[i] <= '0; ed_r[i] <= '0;
        dr_r[i] <= '0; vo_r[i] <= '0; fc_r[i] <= '0;
      end
      h_r <= '0; term_r <= '0; acc_r <= 1'b0; drop_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            typ_r  <= in_tuser;
            now_r  <= in_tdata[47:0];
            fair_r <= in_tdata[87:48];
            px_r   <= in_tdata[111:88];
            qty_r  <= in_tdata[135:112];
            buy_r  <= in_tdata[136];
            own_r  <= in_tdata[144:137];
            bmid_r <= in_tdata[169:145];
            two_r  <= in_tdata[170];
            // park inactive horizons on the write pointer
            for (int i = 0; i < NUM_HORIZONS; i++)
              if (CW'(i) >= nact) rp_r[i] <= wp_r;
          end
          h_r <= '0;
          term_r <= '0;
        end
        ST_PREP: begin
          acc_r  <= take;
          drop_r <= (typ_r == REQ_TRADE) && (own_r == owner_r) && seen_r && full;
          if (take) begin
            wp_r <= wp_r + PW'(1);
            for (int i = 0; i < NUM_HORIZONS; i++)
              if (CW'(i) >= nact) rp_r[i] <= wp_r + PW'(1);
          end
          if (typ_r == REQ_SETTLE && two_r) begin
            mid_r  <= bmid_r;
            seen_r <= 1'b1;
          end
        end
        ST_READ: begin
          // horizon drained: advance to the next one
          if (occ(wp_r, rp_cur) == '0 && !last_h) h_r <= h_r + HW'(1);
        end
        ST_CHECK: begin
          // oldest fill not yet due: advance to the next horizon
          if (!due && !last_h) h_r <= h_r + HW'(1);
        end
        ST_MUL: begin
          case (term_r)
            2'd0: opa_r <= 42'($signed({1'b0, f_mid}) - $signed({1'b0, f_px, 1'b0}));
            2'd1: opa_r <= 42'($signed({1'b0, mid_r}) - $signed({1'b0, f_mid}));
            2'd2: opa_r <= $signed({2'b0, f_fair}) - $signed({2'b0, f_px, 16'b0});
            default: opa_r <= $signed({2'b0, fair_r}) - $signed({2'b0, f_fair});
          endcase
          opb_r <= f_size;
        end
        ST_ACC: begin
          case (term_r)
            2'd0: sp_r[h_r] <= add_out;
            2'd1: ad_r[h_r] <= add_out;
            2'd2: ed_r[h_r] <= add_out;
            default: dr_r[h_r] <= add_out;
          endcase
          term_r <= term_r + 2'd1;
          if (term_r == 2'd3) begin
            rp_r[h_r] <= rp_cur + PW'(1);
            vo_r[h_r] <= (vo_r[h_r] > VOL_MAX - mag) ? VOL_MAX : vo_r[h_r] + mag;
            if (fc_r[h_r] != CNT_MAX) fc_r[h_r] <= fc_r[h_r] + 32'd1;
          end
        end
        ST_EMIT: begin
          // report from horizon zero once every horizon is retired
          h_r <= '0;
        end
        ST_OUT: begin
          if (out_tready && typ_r == REQ_SETTLE && !last_h) h_r <= h_r + HW'(1);
        end
        default: ;
      endcase
    end
  end

  // product register: loaded in ST_PROD, read by the accumulator in ST_ACC
  always_ff @(posedge clk) begin
    prod_r <= opa_r * opb_r;
  end

  // unsettled total over active horizons, counted at report time
  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT) begin
      logic [AW+2:0] t;
      t = '0;
      for (int i = 0; i < NUM_HORIZONS; i++)
        if (CW'(i) < nact) t = t + (AW+3)'(occ_all[i]);
      unst_r <= 9'(t);
    end
  end

  logic [HW-1:0] hout;
  assign hout = (typ_r == REQ_TRADE) ? '0 : h_r;
  assign out_tdata = {7'd0, 9'(unst_r), fc_r[hout], vo_r[hout],
                      dr_r[hout], ed_r[hout], ad_r[hout], sp_r[hout]};
  assign out_tuser = {(typ_r == REQ_TRADE) & drop_r, (typ_r == REQ_TRADE) & acc_r,
                      2'(hout)};
  assign out_tlast = (typ_r == REQ_TRADE) || last_h;

endmodule
